/* rtl/core/hrv_pkg.sv */
// Shared types and constants for the pulse interval RMSSD block.
// Used by hrv_ctrl, hrv_datapath and pulse_interval_hrv_rmssd; no dependencies.
`timescale 1ns / 1ps

package hrv_pkg;

    localparam int unsigned SAMPLE_W   = 10;
    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned INTERVAL_W = 16;
    localparam int unsigned PAIR_W     = 6;
    localparam int unsigned SQ_W       = 2 * INTERVAL_W;   // squared difference
    localparam int unsigned ROOT_W     = SQ_W / 2;         // root of a SQ_W value
    localparam int unsigned ROOT_REM_W = ROOT_W + 2;
    localparam int unsigned PIPE_LAT   = 3;                // read -> diff -> square -> add
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;

    typedef struct packed {
        logic [SAMPLE_W-1:0] pulse_sample;
        logic [STAMP_W-1:0]  time_ms;
    } in_t;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval_ms;
        logic                  interval_saturated;
        logic [PAIR_W-1:0]     pair_count;
        logic [ROOT_W-1:0]     rmssd_ms;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic accept_pulse;   // store interval, start a new request
        logic rd_en;          // read next ring entry, oldest first
        logic rd_first;       // this read opens the walk
        logic div_start;
        logic div_step;
        logic sqrt_start;
        logic sqrt_step;
        logic zero_rms;
        logic load_out;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_pulse;
        logic pairs_zero;
    } status_t;

endpackage

/* rtl/core/hrv_ctrl.sv */
// Sequencer for the RMSSD block: walk, drain, divide, root, hand-off.
// Depends on hrv_pkg.
`timescale 1ns / 1ps

module hrv_ctrl #(
    parameter int unsigned RING_DEPTH = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  hrv_pkg::status_t status,
    output hrv_pkg::cmd_t    cmd
);

    localparam int unsigned SUM_W   = hrv_pkg::SQ_W + $clog2(RING_DEPTH);
    localparam int unsigned CNT_MAX = (RING_DEPTH > SUM_W) ? RING_DEPTH : SUM_W;
    localparam int unsigned CNT_W   = $clog2(CNT_MAX + 1);

    typedef enum logic [2:0] {
        IDLE,
        WALK,
        DRAIN,
        DIV_LOAD,
        DIV,
        SQRT_LOAD,
        SQRT,
        DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             can_load;

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;
    assign can_load  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        unique case (state_reg)
            IDLE:
            begin
                if (in_valid && status.is_pulse)
                begin
                    cmd.accept_pulse = 1'b1;
                    cnt_next         = '0;
                    state_next       = WALK;
                end
            end
            WALK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_first = (cnt_reg == '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(RING_DEPTH - 1))
                begin
                    cnt_next   = '0;
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(hrv_pkg::PIPE_LAT - 1))
                begin
                    state_next = DIV_LOAD;
                end
            end
            DIV_LOAD:
            begin
                cnt_next = '0;
                if (status.pairs_zero)
                begin
                    cmd.zero_rms = 1'b1;
                    state_next   = DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = DIV;
                end
            end
            DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    state_next = SQRT_LOAD;
                end
            end
            SQRT_LOAD:
            begin
                cmd.sqrt_start = 1'b1;
                cnt_next       = '0;
                state_next     = SQRT;
            end
            SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(hrv_pkg::ROOT_W - 1))
                begin
                    state_next = DONE;
                end
            end
            DONE:
            begin
                if (can_load)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* rtl/core/hrv_datapath.sv */
// Datapath: interval ring memory, difference/square/sum pipe, divider, root.
// Depends on hrv_pkg; driven by hrv_ctrl commands.
`timescale 1ns / 1ps

module hrv_datapath #(
    parameter int unsigned RING_DEPTH = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hrv_pkg::SAMPLE_W-1:0]    cfg_wdata,
    input  hrv_pkg::in_t                    in_data,
    input  hrv_pkg::cmd_t                   cmd,
    output hrv_pkg::status_t                status,
    output hrv_pkg::out_t                   out_data
);

    localparam int unsigned IDX_W = $clog2(RING_DEPTH);
    localparam int unsigned SUM_W = hrv_pkg::SQ_W + $clog2(RING_DEPTH);
    localparam int unsigned IW    = hrv_pkg::INTERVAL_W;
    localparam int unsigned PW    = hrv_pkg::PAIR_W;
    localparam int unsigned RW    = hrv_pkg::ROOT_W;
    localparam int unsigned RRW   = hrv_pkg::ROOT_REM_W;
    localparam int unsigned SQW   = hrv_pkg::SQ_W;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        return (p == IDX_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // configuration
    logic [hrv_pkg::SAMPLE_W-1:0] threshold_reg;

    // pulse front end
    logic [hrv_pkg::STAMP_W-1:0]  last_stamp_reg;
    logic [hrv_pkg::STAMP_W-1:0]  elapsed;
    logic                         sat;
    logic [IW-1:0]                interval;
    logic [IW-1:0]                interval_reg;
    logic                         sat_reg;

    // ring
    logic [IW-1:0]                ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0]        ring_valid_reg;
    logic [IDX_W-1:0]             wr_pos_reg;
    logic [IDX_W-1:0]             rd_ptr_reg;
    logic [IW-1:0]                rd_data_reg;
    logic                         rd_ok_reg;
    logic [IW-1:0]                entry;

    // walk pipe
    logic                         s1_v_reg, s1_first_reg;
    logic                         s2_v_reg, s3_v_reg;
    logic [IW-1:0]                prev_reg;
    logic [IW-1:0]                diff_reg;
    logic [SQW-1:0]               sq_reg;
    logic [SUM_W-1:0]             acc_reg;
    logic [PW-1:0]                pairs_reg;

    // divider and root
    logic [SUM_W-1:0]             quo_reg;
    logic [PW:0]                  drem_reg;
    logic [PW:0]                  drem_sh;
    logic                         dq_bit;
    logic [SQW-1:0]               rad_reg;
    logic [RRW-1:0]               rrem_reg;
    logic [RRW-1:0]               rrem_sh;
    logic [RRW-1:0]               trial;
    logic [RW-1:0]                root_reg;

    assign elapsed  = in_data.time_ms - last_stamp_reg;
    assign sat      = |elapsed[hrv_pkg::STAMP_W-1:IW];
    assign interval = sat ? {IW{1'b1}} : elapsed[IW-1:0];

    assign status.is_pulse   = in_data.pulse_sample > threshold_reg;
    assign status.pairs_zero = (pairs_reg == '0);

    assign entry = rd_ok_reg ? rd_data_reg : '0;

    assign drem_sh = {drem_reg[PW-1:0], quo_reg[SUM_W-1]};
    assign dq_bit  = drem_sh >= {1'b0, pairs_reg};

    assign rrem_sh = {rrem_reg[RRW-3:0], rad_reg[SQW-1 -: 2]};
    assign trial   = {root_reg, 2'b01};

    // control state: pointers, stamp, valid bits, pipe flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= hrv_pkg::THRESHOLD_RESET;
            last_stamp_reg <= '0;
            ring_valid_reg <= '0;
            wr_pos_reg     <= '0;
            rd_ptr_reg     <= '0;
            s1_v_reg       <= 1'b0;
            s1_first_reg   <= 1'b0;
            s2_v_reg       <= 1'b0;
            s3_v_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                threshold_reg <= cfg_wdata;
            end
            if (cmd.accept_pulse)
            begin
                last_stamp_reg             <= in_data.time_ms;
                ring_valid_reg[wr_pos_reg] <= 1'b1;
                wr_pos_reg                 <= wrap_inc(wr_pos_reg);
                rd_ptr_reg                 <= wrap_inc(wr_pos_reg);  // oldest entry
            end
            else if (cmd.rd_en)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            s1_v_reg     <= cmd.rd_en;
            s1_first_reg <= cmd.rd_first;
            s2_v_reg     <= s1_v_reg && !s1_first_reg && (prev_reg != '0) && (entry != '0);
            s3_v_reg     <= s2_v_reg;
        end
    end

    // ring memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept_pulse)
        begin
            ring_mem[wr_pos_reg] <= interval;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= ring_mem[rd_ptr_reg];
            rd_ok_reg   <= ring_valid_reg[rd_ptr_reg];
        end
    end

    // arithmetic payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept_pulse)
        begin
            interval_reg <= interval;
            sat_reg      <= sat;
            acc_reg      <= '0;
            pairs_reg    <= '0;
        end
        if (s1_v_reg)
        begin
            prev_reg <= entry;
            diff_reg <= (prev_reg > entry) ? prev_reg - entry : entry - prev_reg;
        end
        sq_reg <= diff_reg * diff_reg;
        if (s3_v_reg)
        begin
            acc_reg   <= acc_reg + SUM_W'(sq_reg);
            pairs_reg <= pairs_reg + 1'b1;
        end

        // restoring divider, one quotient bit per step
        if (cmd.div_start)
        begin
            quo_reg  <= acc_reg;
            drem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg  <= {quo_reg[SUM_W-2:0], dq_bit};
            drem_reg <= dq_bit ? drem_sh - {1'b0, pairs_reg} : drem_sh;
        end

        // digit-by-digit root, one result bit per step
        if (cmd.sqrt_start)
        begin
            rad_reg  <= quo_reg[SQW-1:0];   // mean never exceeds one square
            rrem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rad_reg <= {rad_reg[SQW-3:0], 2'b00};
            if (rrem_sh >= trial)
            begin
                rrem_reg <= rrem_sh - trial;
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rrem_reg <= rrem_sh;
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        else if (cmd.zero_rms)
        begin
            root_reg <= '0;
        end

        if (cmd.load_out)
        begin
            out_data.interval_ms        <= interval_reg;
            out_data.interval_saturated <= sat_reg;
            out_data.pair_count         <= pairs_reg;
            out_data.rmssd_ms           <= root_reg;
        end
    end

endmodule

/* rtl/core/pulse_interval_hrv_rmssd.sv */
// Top level of the pulse interval RMSSD block: controller plus datapath.
// Depends on hrv_pkg, hrv_ctrl and hrv_datapath.
`timescale 1ns / 1ps

// Every accepted sample whose pulse_sample is strictly above threshold_reg
// (reset 512, written through cfg_we/cfg_wdata) counts as a pulse; other
// samples are accepted while idle and give no result. A pulse stores the
// interval since the previous pulse (32-bit stamp difference, clipped to
// 65535 with a flag) in a ring of RING_DEPTH entries, zero meaning empty,
// and yields one result with the interval, the count of successive nonzero
// pairs in time order and the floor RMSSD. One pulse request runs a walk
// over the ring memory through a difference/square/accumulate pipe, a
// restoring divider giving one quotient bit per cycle, and a square root
// giving one bit per cycle. A pulse with no valid pair skips divider and
// root. The ring's empty state comes from per-entry valid flops cleared at
// reset, so no clearing pass is needed. A finished result sits in an output
// register, so the next sample is accepted while it waits; a pulse request
// only stalls at its end if the previous result has not been taken.

module pulse_interval_hrv_rmssd #(
    parameter int unsigned RING_DEPTH = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [hrv_pkg::SAMPLE_W-1:0] cfg_wdata,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  hrv_pkg::in_t                 in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output hrv_pkg::out_t                out_data
);

    hrv_pkg::cmd_t    cmd;
    hrv_pkg::status_t status;

    // sequencer: owns handshakes and step counts
    hrv_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // ring, arithmetic and the output register
    hrv_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

/* tb/sv/pulse_interval_hrv_rmssd_tb.sv */
// Self-checking testbench for pulse_interval_hrv_rmssd: queued sample requests,
// an in-bench interval/RMSSD predictor and an in-order result checker.
// Depends on hrv_pkg and the pulse_interval_hrv_rmssd RTL.
`timescale 1ns / 1ps

module pulse_interval_hrv_rmssd_tb;

    localparam int unsigned RING_DEPTH  = 10;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Settle longer than one pulse request takes at depth 10.
    localparam int unsigned SETTLE_CYCLES = 100;
    localparam int unsigned HOLD_CYCLES   = 600;
    localparam int unsigned HOLD_AFTER    = 260;   // pulses taken before the hold-off
    localparam int unsigned IDLE_PCT      = 16;
    localparam int unsigned MAX_REPORTS   = 10;

    // ------------------------------------------------------------------
    // DUT signals; the bench-driven ones are known from time zero
    // ------------------------------------------------------------------
    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [hrv_pkg::SAMPLE_W-1:0] cfg_wdata = '0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    hrv_pkg::in_t                 in_data   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    hrv_pkg::out_t                out_data;

    pulse_interval_hrv_rmssd #(
        .RING_DEPTH(RING_DEPTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    hrv_pkg::in_t  pending_samples[$];   // requests waiting for the driver
    hrv_pkg::out_t rmssd_expected[$];    // predicted results, oldest first
    int unsigned   mismatch_count = 0;
    int unsigned   pulses_taken   = 0;
    int unsigned   cycle_count    = 0;
    int unsigned   idle_pct       = IDLE_PCT;
    logic          rx_hold        = 1'b0;

    // Predictor copy of the block state. Reset happens once, so the
    // declaration values are the post-reset state.
    logic [hrv_pkg::SAMPLE_W-1:0]   threshold_model = hrv_pkg::THRESHOLD_RESET;
    logic [hrv_pkg::STAMP_W-1:0]    last_pulse_model = '0;
    logic [hrv_pkg::INTERVAL_W-1:0] interval_model[RING_DEPTH] = '{default: '0};
    int unsigned                    wr_slot_model = 0;

    // Stimulus generator view: threshold it builds for and last pulse stamp.
    logic [hrv_pkg::SAMPLE_W-1:0]   gen_thr    = hrv_pkg::THRESHOLD_RESET;
    logic [hrv_pkg::STAMP_W-1:0]    gen_cursor = '0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Floor square root, one result bit at a time from the top.
    function automatic logic [hrv_pkg::ROOT_W-1:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = hrv_pkg::ROOT_W - 1; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v)
                root = trial;
        end
        return root[hrv_pkg::ROOT_W-1:0];
    endfunction

    // Applies one accepted request to the state copy; a pulse queues a result.
    function automatic void predict_rmssd(input hrv_pkg::in_t req);
        hrv_pkg::out_t                  res;
        logic [hrv_pkg::STAMP_W-1:0]    elapsed;
        logic [hrv_pkg::INTERVAL_W-1:0] iv;
        logic [63:0]                    sum;
        logic [63:0]                    d;
        int unsigned                    pos;
        int unsigned                    nxt;
        int unsigned                    pairs;
        if (req.pulse_sample <= threshold_model)
            return;
        elapsed          = req.time_ms - last_pulse_model;   // mod 2^32
        last_pulse_model = req.time_ms;
        res.interval_saturated = (elapsed > 32'h0000_FFFF);
        iv = res.interval_saturated ? 16'hFFFF : elapsed[hrv_pkg::INTERVAL_W-1:0];
        res.interval_ms = iv;
        interval_model[wr_slot_model] = iv;
        wr_slot_model = (wr_slot_model + 1) % RING_DEPTH;
        // oldest entry now sits at the write slot; walk forward in time
        pos   = wr_slot_model;
        pairs = 0;
        sum   = '0;
        for (int k = 0; k < RING_DEPTH - 1; k++)
        begin
            nxt = (pos + 1) % RING_DEPTH;
            if (interval_model[pos] != 0 && interval_model[nxt] != 0)
            begin
                if (interval_model[pos] > interval_model[nxt])
                    d = interval_model[pos] - interval_model[nxt];
                else
                    d = interval_model[nxt] - interval_model[pos];
                sum   = sum + d * d;
                pairs = pairs + 1;
            end
            pos = nxt;
        end
        res.pair_count = pairs[hrv_pkg::PAIR_W-1:0];
        res.rmssd_ms   = (pairs != 0) ? floor_root(sum / pairs) : '0;
        rmssd_expected.push_back(res);
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, run limit
    // ------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Driver: feeds pending_samples into the input channel. The payload
    // only changes when the slot is free, so valid/data hold while stalled.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (in_data.pulse_sample > threshold_model)
                    pulses_taken <= pulses_taken + 1;
                predict_rmssd(in_data);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_samples.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_samples.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken result against the oldest prediction and
    // drives out_ready (random idling, plus the long hold-off).
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        hrv_pkg::out_t exp_res;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rmssd_expected.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < MAX_REPORTS)
                        $display("ERROR: result with nothing pending: %p", out_data);
                end
                else
                begin
                    exp_res = rmssd_expected.pop_front();
                    if (out_data.interval_ms !== exp_res.interval_ms
                        || out_data.interval_saturated !== exp_res.interval_saturated
                        || out_data.pair_count !== exp_res.pair_count
                        || out_data.rmssd_ms !== exp_res.rmssd_ms)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < MAX_REPORTS)
                            $display("ERROR exp/act iv %0d/%0d sat %0d/%0d pr %0d/%0d rms %0d/%0d",
                                     exp_res.interval_ms, out_data.interval_ms,
                                     exp_res.interval_saturated, out_data.interval_saturated,
                                     exp_res.pair_count, out_data.pair_count,
                                     exp_res.rmssd_ms, out_data.rmssd_ms);
                    end
                end
            end
            out_ready <= !rx_hold && ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Long receiver hold-off in the middle of a pulse-heavy phase: the
    // output register fills, the next pulse request stalls at its end and
    // in_ready drops while the driver keeps offering.
    initial
    begin
        do @(posedge clk); while (pulses_taken < HOLD_AFTER);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_sample(input logic [hrv_pkg::SAMPLE_W-1:0] sample,
                                input logic [hrv_pkg::STAMP_W-1:0] stamp);
        hrv_pkg::in_t req;
        req.pulse_sample = sample;
        req.time_ms      = stamp;
        pending_samples.push_back(req);
        if (sample > gen_thr)
            gen_cursor = stamp;
    endtask

    function automatic logic [hrv_pkg::SAMPLE_W-1:0] pulse_level();
        return hrv_pkg::SAMPLE_W'($urandom_range(gen_thr + 1, 1023));
    endfunction

    function automatic logic [hrv_pkg::SAMPLE_W-1:0] quiet_level();
        return hrv_pkg::SAMPLE_W'($urandom_range(0, gen_thr));
    endfunction

    // Mostly regular heart beats with sub-threshold samples in between;
    // the rest exercises wide, clipped, zero and wrapped intervals.
    task automatic queue_beats(input int unsigned n_pulses);
        int unsigned                 kind;
        int unsigned                 n_quiet;
        logic [hrv_pkg::STAMP_W-1:0] t;
        for (int unsigned p = 0; p < n_pulses; p++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                n_quiet = $urandom_range(0, 3);
                t = gen_cursor;
                for (int unsigned q = 0; q < n_quiet; q++)
                begin
                    t = t + $urandom_range(1, 250);
                    queue_sample(quiet_level(), t);
                end
                queue_sample(pulse_level(), gen_cursor + $urandom_range(300, 1600));
            end
            else if (kind < 78)
                queue_sample(pulse_level(), gen_cursor + $urandom_range(1, 65535));
            else if (kind < 83)
                queue_sample(pulse_level(),
                             gen_cursor + 32'h0001_0000 + $urandom_range(0, 1 << 20));
            else if (kind < 88)
                queue_sample(pulse_level(), gen_cursor);                 // zero interval
            else if (kind < 93)
            begin
                queue_sample(quiet_level(), $urandom);                  // noise
                queue_sample(pulse_level(), $urandom);
            end
            else
                queue_sample(pulse_level(), 32'hFFFF_FFFF - $urandom_range(0, 1500));
        end
    endtask

    task automatic queue_noise(input int unsigned n);
        for (int unsigned i = 0; i < n; i++)
            queue_sample(hrv_pkg::SAMPLE_W'($urandom_range(0, 1023)), $urandom);
    endtask

    // Waits until every request is taken and every result checked, then
    // lets the block settle before the next register write.
    task automatic drain_and_settle();
        do @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || rmssd_expected.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [hrv_pkg::SAMPLE_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        threshold_model = value;
        gen_thr         = value;
        @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [hrv_pkg::SAMPLE_W-1:0] mid_thr;
        @(posedge rst_n);
        @(negedge clk);

        // Directed requests at the reset threshold of 512.
        queue_sample(10'd512, 32'd100);            // equal to threshold: ignored
        queue_sample(10'd0, 32'd0);                // lowest sample and stamp
        queue_sample(10'd513, 32'd1000);           // first pulse, measured from 0
        queue_sample(10'd1023, 32'd1800);
        queue_sample(10'd0, 32'd1900);
        queue_sample(10'd600, 32'd1800);           // same stamp: zero interval
        queue_sample(10'd700, 32'd2600);
        queue_sample(10'd800, 32'd2601);           // shortest interval
        queue_sample(10'd900, 32'd68136);          // 65535 exactly, not clipped
        queue_sample(10'd901, 32'd133672);         // 65536: clipped
        queue_sample(10'd1023, 32'hFFFF_FFFF);     // largest stamp, clipped
        queue_sample(10'd1023, 32'h0000_0010);     // stamp wrap: 17 ms
        // Alternate 1 and 65535 ms to push the RMSSD to its top and fill
        // the ring so all nine pairs count.
        for (int i = 0; i < 8; i++)
            queue_sample(10'd1023, gen_cursor + ((i % 2) ? 32'd65535 : 32'd1));
        drain_and_settle();

        // Lowest threshold, no idling on either side for the whole phase.
        idle_pct <= 0;
        write_threshold(10'd0);
        queue_beats(120);
        drain_and_settle();
        idle_pct <= IDLE_PCT;

        // Highest threshold: nothing can count as a pulse.
        write_threshold(10'd1023);
        queue_noise(30);
        drain_and_settle();

        // Random threshold; the receiver hold-off lands in this phase.
        mid_thr = hrv_pkg::SAMPLE_W'($urandom_range(1, 1022));
        write_threshold(mid_thr);
        queue_beats(300);
        drain_and_settle();

        // Only full-scale samples count.
        write_threshold(10'd1022);
        queue_beats(50);
        drain_and_settle();

        write_threshold(hrv_pkg::THRESHOLD_RESET);
        queue_beats(240);
        drain_and_settle();

        if (mismatch_count == 0 && rmssd_expected.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
